// ===== hw/rtl/rrbl_pkg.sv =====
// shared constants, codes and controller/datapath interface types
package rrbl_pkg;

  localparam int RULE_SLOTS = 64;
  localparam int EP_SLOTS   = 130;
  localparam int RW         = 6;   // rule slot index bits
  localparam int EW         = 8;   // endpoint index / count bits
  localparam int KW         = 32;  // key and bound width
  localparam int VW         = 64;  // rule vector width
  localparam int CW         = 7;   // count width

  localparam logic [CW-1:0] RULE_MAX = 7'd64;

  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_BUILD  = 2'd1;
  localparam logic [1:0] ACT_LOOKUP = 2'd2;
  localparam logic [1:0] ACT_NONE   = 2'd3;

  localparam logic [1:0] DOM_32 = 2'd0;
  localparam logic [1:0] DOM_8  = 2'd1;

  localparam logic [KW-1:0] DMAX_32 = 32'hFFFF_FFFF;
  localparam logic [KW-1:0] DMAX_8  = 32'd255;
  localparam logic [KW-1:0] DMAX_16 = 32'd65535;

  localparam logic CFG_RULE_COUNT = 1'b0;
  localparam logic CFG_KEY_DOMAIN = 1'b1;

  // endpoint memory read address select
  localparam logic [1:0] EA_I    = 2'd0;
  localparam logic [1:0] EA_I1   = 2'd1;
  localparam logic [1:0] EA_MID  = 2'd2;
  localparam logic [1:0] EA_LOM1 = 2'd3;

  typedef struct packed {
    logic       capture;
    logic       load_wr;
    logic       bld_init;
    logic       pass_init;
    logic       sort_lo;
    logic       sort_hi;
    logic       sort_end;
    logic       r_inc;
    logic       vec_e;
    logic       vec_en;
    logic       vec_cmp;
    logic       vec_wr;
    logic       srch_init;
    logic       srch_mid;
    logic       srch_cmp;
    logic       pick_zero;
    logic       pick;
    logic       count;
    logic       out_load;
    logic       kind_build;
    logic [1:0] ep_sel;
  } cmd_t;

  typedef struct packed {
    logic [1:0] act;
    logic       lt;
    logic       lo_zero;
    logic       n_zero;
    logic       r_last;
    logic       best_ok;
    logic       i_last;
    logic       out_free;
  } sts_t;

endpackage

// ===== hw/rtl/rrbl_ctrl.sv =====
// controller state machine: sequences load, build and lookup
module rrbl_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  rrbl_pkg::sts_t   sts,
  output rrbl_pkg::cmd_t   cmd
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_DISP  = 5'd1;
  localparam logic [4:0] S_PASS  = 5'd2;
  localparam logic [4:0] S_SRD   = 5'd3;
  localparam logic [4:0] S_SLO   = 5'd4;
  localparam logic [4:0] S_SHI   = 5'd5;
  localparam logic [4:0] S_SEND  = 5'd6;
  localparam logic [4:0] S_VE    = 5'd7;
  localparam logic [4:0] S_VE2   = 5'd8;
  localparam logic [4:0] S_VE3   = 5'd9;
  localparam logic [4:0] S_VRD   = 5'd10;
  localparam logic [4:0] S_VCMP  = 5'd11;
  localparam logic [4:0] S_VWR   = 5'd12;
  localparam logic [4:0] S_BRES  = 5'd13;
  localparam logic [4:0] S_SRCH  = 5'd14;
  localparam logic [4:0] S_SCMP  = 5'd15;
  localparam logic [4:0] S_FETCH = 5'd16;
  localparam logic [4:0] S_PICK  = 5'd17;
  localparam logic [4:0] S_CNT   = 5'd18;
  localparam logic [4:0] S_LRES  = 5'd19;

  logic [4:0] state;
  logic [4:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.ep_sel = rrbl_pkg::EA_I;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.act)
          rrbl_pkg::ACT_LOAD: begin
            cmd.load_wr = 1'b1;
            state_next  = S_IDLE;
          end
          rrbl_pkg::ACT_BUILD: begin
            cmd.bld_init = 1'b1;
            state_next   = S_PASS;
          end
          rrbl_pkg::ACT_LOOKUP: begin
            cmd.srch_init = 1'b1;
            state_next    = S_SRCH;
          end
          default: state_next = S_IDLE;
        endcase
      end
      // one pass finds the next larger distinct endpoint
      S_PASS: begin
        cmd.pass_init = 1'b1;
        state_next    = sts.n_zero ? S_SEND : S_SRD;
      end
      S_SRD: state_next = S_SLO;
      S_SLO: begin
        cmd.sort_lo = 1'b1;
        state_next  = S_SHI;
      end
      S_SHI: begin
        cmd.sort_hi = 1'b1;
        cmd.r_inc   = 1'b1;
        state_next  = sts.r_last ? S_SEND : S_SRD;
      end
      S_SEND: begin
        cmd.sort_end = 1'b1;
        state_next   = sts.best_ok ? S_PASS : S_VE;
      end
      S_VE: begin
        cmd.ep_sel = rrbl_pkg::EA_I;
        state_next = S_VE2;
      end
      S_VE2: begin
        cmd.vec_e  = 1'b1;
        cmd.ep_sel = rrbl_pkg::EA_I1;
        state_next = S_VE3;
      end
      S_VE3: begin
        cmd.vec_en = 1'b1;
        state_next = sts.n_zero ? S_VWR : S_VRD;
      end
      S_VRD: state_next = S_VCMP;
      S_VCMP: begin
        cmd.vec_cmp = 1'b1;
        cmd.r_inc   = 1'b1;
        state_next  = sts.r_last ? S_VWR : S_VRD;
      end
      S_VWR: begin
        cmd.vec_wr = 1'b1;
        state_next = sts.i_last ? S_BRES : S_VE;
      end
      S_BRES: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.kind_build = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_SRCH: begin
        cmd.ep_sel = rrbl_pkg::EA_MID;
        if (sts.lt) begin
          cmd.srch_mid = 1'b1;
          state_next   = S_SCMP;
        end else begin
          state_next = S_FETCH;
        end
      end
      S_SCMP: begin
        cmd.srch_cmp = 1'b1;
        state_next   = S_SRCH;
      end
      S_FETCH: begin
        cmd.ep_sel = rrbl_pkg::EA_LOM1;
        if (sts.lo_zero) begin
          cmd.pick_zero = 1'b1;
          state_next    = S_CNT;
        end else begin
          state_next = S_PICK;
        end
      end
      S_PICK: begin
        cmd.pick   = 1'b1;
        state_next = S_CNT;
      end
      S_CNT: begin
        cmd.count  = 1'b1;
        state_next = S_LRES;
      end
      S_LRES: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hw/rtl/rrbl_datapath.sv =====
// datapath: config registers, bound/endpoint/vector memories, compares, result register
module rrbl_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic                                cfg_index,
  input  logic [rrbl_pkg::CW-1:0]             cfg_data,
  input  logic [1:0]                          action,
  input  logic [rrbl_pkg::RW-1:0]             rule_index,
  input  logic [rrbl_pkg::KW-1:0]             range_low,
  input  logic [rrbl_pkg::KW-1:0]             range_high,
  input  logic [rrbl_pkg::KW-1:0]             search_key,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                result_kind,
  output logic [rrbl_pkg::VW-1:0]             match_vector,
  output logic [rrbl_pkg::CW-1:0]             match_count,
  input  rrbl_pkg::cmd_t                      cmd,
  output rrbl_pkg::sts_t                      sts
);

  // config
  logic [rrbl_pkg::CW-1:0] rule_count;
  logic [1:0]              key_domain;

  // captured item
  logic [1:0]              act;
  logic [rrbl_pkg::RW-1:0] slot;
  logic [rrbl_pkg::KW-1:0] cap_lo;
  logic [rrbl_pkg::KW-1:0] cap_hi;
  logic [rrbl_pkg::KW-1:0] key;

  // memories
  logic [rrbl_pkg::KW-1:0] blo_mem [rrbl_pkg::RULE_SLOTS];
  logic [rrbl_pkg::KW-1:0] bhi_mem [rrbl_pkg::RULE_SLOTS];
  logic [rrbl_pkg::KW-1:0] ep_mem  [rrbl_pkg::EP_SLOTS];
  logic [rrbl_pkg::VW-1:0] pv_mem  [rrbl_pkg::EP_SLOTS];
  logic [rrbl_pkg::VW-1:0] gv_mem  [rrbl_pkg::EP_SLOTS];
  logic [rrbl_pkg::KW-1:0] lo_q;
  logic [rrbl_pkg::KW-1:0] hi_q;
  logic [rrbl_pkg::KW-1:0] ep_q;
  logic [rrbl_pkg::VW-1:0] pv_q;
  logic [rrbl_pkg::VW-1:0] gv_q;

  // build state
  logic [rrbl_pkg::RW-1:0] r;
  logic [rrbl_pkg::EW-1:0] k;
  logic [rrbl_pkg::EW-1:0] i;
  logic [rrbl_pkg::EW-1:0] total;
  logic [rrbl_pkg::KW-1:0] prev;
  logic                    have_prev;
  logic [rrbl_pkg::KW-1:0] best;
  logic                    best_ok;
  logic [rrbl_pkg::KW-1:0] e;
  logic [rrbl_pkg::KW-1:0] en;
  logic [rrbl_pkg::VW-1:0] pv;
  logic [rrbl_pkg::VW-1:0] gv;

  // search state
  logic [rrbl_pkg::EW-1:0] s_lo;
  logic [rrbl_pkg::EW-1:0] s_hi;
  logic [rrbl_pkg::EW-1:0] mid;
  logic [rrbl_pkg::VW-1:0] vec;
  logic [rrbl_pkg::CW-1:0] cnt;

  logic [rrbl_pkg::CW-1:0] n_rules;
  logic [rrbl_pkg::KW-1:0] dmax;
  logic [rrbl_pkg::EW:0]   mid_sum;
  logic [rrbl_pkg::EW-1:0] mid_c;
  logic [rrbl_pkg::EW-1:0] i_inc;
  logic [rrbl_pkg::EW-1:0] lo_m1;
  logic [rrbl_pkg::EW-1:0] ep_addr;
  logic                    q_lo;
  logic                    q_hi;
  logic                    has_next;

  // pairwise adder tree, six levels for 64 bits
  function automatic logic [rrbl_pkg::CW-1:0] ones(input logic [rrbl_pkg::VW-1:0] v);
    logic [rrbl_pkg::CW-1:0] s [rrbl_pkg::VW];
    for (int b = 0; b < rrbl_pkg::VW; b++) begin
      s[b] = {{(rrbl_pkg::CW-1){1'b0}}, v[b]};
    end
    for (int w = rrbl_pkg::VW / 2; w >= 1; w = w / 2) begin
      for (int b = 0; b < w; b++) begin
        s[b] = s[2*b] + s[2*b+1];
      end
    end
    return s[0];
  endfunction

  assign n_rules = (rule_count > rrbl_pkg::RULE_MAX) ? rrbl_pkg::RULE_MAX : rule_count;

  always_comb begin
    if (key_domain == rrbl_pkg::DOM_32) begin
      dmax = rrbl_pkg::DMAX_32;
    end else if (key_domain == rrbl_pkg::DOM_8) begin
      dmax = rrbl_pkg::DMAX_8;
    end else begin
      dmax = rrbl_pkg::DMAX_16;  // domains 2 and 3 behave as 16-bit
    end
  end

  assign mid_sum  = {1'b0, s_lo} + {1'b0, s_hi};
  assign mid_c    = mid_sum[rrbl_pkg::EW:1];
  assign i_inc    = i + 8'd1;
  assign lo_m1    = s_lo - 8'd1;
  assign has_next = (i_inc < total);

  always_comb begin
    case (cmd.ep_sel)
      rrbl_pkg::EA_I:   ep_addr = i;
      rrbl_pkg::EA_I1:  ep_addr = i_inc;
      rrbl_pkg::EA_MID: ep_addr = mid_c;
      default:          ep_addr = lo_m1;
    endcase
  end

  // candidate qualifies when above the last endpoint and below the best so far
  assign q_lo = (!have_prev || lo_q > prev) && (!best_ok || lo_q < best);
  assign q_hi = (!have_prev || hi_q > prev) && (!best_ok || hi_q < best);

  assign sts.act      = act;
  assign sts.lt       = (s_lo < s_hi);
  assign sts.lo_zero  = (s_lo == '0);
  assign sts.n_zero   = (n_rules == '0);
  assign sts.r_last   = (({1'b0, r} + 7'd1) == n_rules);
  assign sts.best_ok  = best_ok;
  assign sts.i_last   = (i_inc == total);
  assign sts.out_free = !out_valid || out_ready;

  // memories
  always_ff @(posedge clk) begin
    if (cmd.load_wr) begin
      blo_mem[slot] <= cap_lo;
      bhi_mem[slot] <= cap_hi;
    end
    lo_q <= blo_mem[r];
    hi_q <= bhi_mem[r];
  end

  always_ff @(posedge clk) begin
    if (cmd.sort_end && best_ok && k < 8'(rrbl_pkg::EP_SLOTS)) begin
      ep_mem[k] <= best;
    end
    if (ep_addr < 8'(rrbl_pkg::EP_SLOTS)) begin
      ep_q <= ep_mem[ep_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.vec_wr) begin
      pv_mem[i] <= pv;
      gv_mem[i] <= gv;
    end
    if (ep_addr < 8'(rrbl_pkg::EP_SLOTS)) begin
      pv_q <= pv_mem[ep_addr];
      gv_q <= gv_mem[ep_addr];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rule_count <= '0;
      key_domain <= '0;
      total      <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == rrbl_pkg::CFG_RULE_COUNT) begin
          rule_count <= cfg_data;
        end else begin
          key_domain <= cfg_data[1:0];
        end
      end
      if (cmd.bld_init) begin
        total <= '0;
      end else if (cmd.sort_end && !best_ok) begin
        total <= k;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act    <= action;
      slot   <= rule_index;
      cap_lo <= range_low;
      cap_hi <= range_high;
      key    <= search_key;
    end
    if (cmd.bld_init) begin
      k         <= '0;
      have_prev <= 1'b0;
    end
    if (cmd.pass_init) begin
      r <= '0;
      if (!have_prev) begin
        best    <= '0;
        best_ok <= 1'b1;
      end else if (dmax > prev) begin
        best    <= dmax;
        best_ok <= 1'b1;
      end else begin
        best_ok <= 1'b0;
      end
    end
    if (cmd.sort_lo && q_lo) begin
      best    <= lo_q;
      best_ok <= 1'b1;
    end
    if (cmd.sort_hi && q_hi) begin
      best    <= hi_q;
      best_ok <= 1'b1;
    end
    if (cmd.r_inc) begin
      r <= r + 6'd1;
    end
    if (cmd.sort_end) begin
      if (best_ok) begin
        prev      <= best;
        have_prev <= 1'b1;
        k         <= k + 8'd1;
      end else begin
        i <= '0;
      end
    end
    if (cmd.vec_e) begin
      e <= ep_q;
    end
    if (cmd.vec_en) begin
      en <= ep_q;
      pv <= '0;
      gv <= '0;
      r  <= '0;
    end
    if (cmd.vec_cmp) begin
      if (lo_q <= e && hi_q >= e) begin
        pv[r] <= 1'b1;
      end
      if (has_next && lo_q <= e && hi_q >= en) begin
        gv[r] <= 1'b1;
      end
    end
    if (cmd.vec_wr) begin
      i <= i_inc;
    end
    if (cmd.srch_init) begin
      s_lo <= '0;
      s_hi <= total;
    end
    if (cmd.srch_mid) begin
      mid <= mid_c;
    end
    if (cmd.srch_cmp) begin
      if (ep_q <= key) begin
        s_lo <= mid + 8'd1;
      end else begin
        s_hi <= mid;
      end
    end
    if (cmd.pick_zero) begin
      vec <= '0;
    end
    if (cmd.pick) begin
      if (ep_q == key) begin
        vec <= pv_q;
      end else if (s_lo >= total) begin
        vec <= '0;
      end else begin
        vec <= gv_q;
      end
    end
    if (cmd.count) begin
      cnt <= ones(vec);
    end
    if (cmd.out_load) begin
      result_kind  <= cmd.kind_build;
      match_vector <= cmd.kind_build ? '0 : vec;
      match_count  <= cmd.kind_build ? '0 : cnt;
    end
  end

endmodule

// ===== hw/rtl/range_rule_bitvector_lookup.sv =====
// top level: one-dimension range classifier with per-interval rule vectors
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+----------------------------------------------
//  in       | in_valid / in_ready        | action rule_index range_low range_high search_key
//  out      | out_valid / out_ready      | result_kind match_vector match_count
//  cfg      | cfg_write (no wait)        | cfg_index cfg_data
//
//  load: one write to the bound memories. lookup: binary-search probes of the endpoint
//  memory (up to 8 probes), then the vector pick and the count.
//  build: selection sort over the bound memories, one pass over the rules per endpoint,
//  then one pass over the rules per endpoint for the vectors.
//  rst is synchronous; memories are not cleared, the endpoint count resets to zero.
//  a finished result waits in the output register while the next item is taken.
module range_rule_bitvector_lookup (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic                        cfg_index,
  input  logic [rrbl_pkg::CW-1:0]     cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  action,
  input  logic [rrbl_pkg::RW-1:0]     rule_index,
  input  logic [rrbl_pkg::KW-1:0]     range_low,
  input  logic [rrbl_pkg::KW-1:0]     range_high,
  input  logic [rrbl_pkg::KW-1:0]     search_key,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        result_kind,
  output logic [rrbl_pkg::VW-1:0]     match_vector,
  output logic [rrbl_pkg::CW-1:0]     match_count
);

  rrbl_pkg::cmd_t cmd;
  rrbl_pkg::sts_t sts;

  rrbl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rrbl_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .action       (action),
    .rule_index   (rule_index),
    .range_low    (range_low),
    .range_high   (range_high),
    .search_key   (search_key),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_kind  (result_kind),
    .match_vector (match_vector),
    .match_count  (match_count),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule

// ===== tb/tb_top.sv =====
// testbench for range_rule_bitvector_lookup: directed table then random phases
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT = 3_000_000;

  typedef struct {
    logic                      kind;
    logic [rrbl_pkg::VW-1:0]   vec;
    logic [rrbl_pkg::CW-1:0]   cnt;
  } answer_t;

  typedef struct {
    bit                        sync;   // wait for idle and write config before this row
    logic [rrbl_pkg::CW-1:0]   rc;
    logic [1:0]                dom;
    logic [1:0]                act;
    logic [rrbl_pkg::RW-1:0]   idx;
    logic [rrbl_pkg::KW-1:0]   lo;
    logic [rrbl_pkg::KW-1:0]   hi;
    logic [rrbl_pkg::KW-1:0]   key;
    bit                        typed;  // expected vector given in the row
    logic [rrbl_pkg::VW-1:0]   vec;
  } row_t;

  logic                      clk;
  logic                      rst;
  logic                      cfg_write;
  logic                      cfg_index;
  logic [rrbl_pkg::CW-1:0]   cfg_data;
  logic                      in_valid;
  logic                      in_ready;
  logic [1:0]                action;
  logic [rrbl_pkg::RW-1:0]   rule_index;
  logic [rrbl_pkg::KW-1:0]   range_low;
  logic [rrbl_pkg::KW-1:0]   range_high;
  logic [rrbl_pkg::KW-1:0]   search_key;
  logic                      out_valid;
  logic                      out_ready;
  logic                      result_kind;
  logic [rrbl_pkg::VW-1:0]   match_vector;
  logic [rrbl_pkg::CW-1:0]   match_count;

  range_rule_bitvector_lookup u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .rule_index   (rule_index),
    .range_low    (range_low),
    .range_high   (range_high),
    .search_key   (search_key),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_kind  (result_kind),
    .match_vector (match_vector),
    .match_count  (match_count)
  );

  // classifier mirror
  logic [rrbl_pkg::KW-1:0] bnd_lo [rrbl_pkg::RULE_SLOTS];
  logic [rrbl_pkg::KW-1:0] bnd_hi [rrbl_pkg::RULE_SLOTS];
  logic [rrbl_pkg::KW-1:0] edges [rrbl_pkg::EP_SLOTS];
  logic [rrbl_pkg::VW-1:0] edge_vec [rrbl_pkg::EP_SLOTS];
  logic [rrbl_pkg::VW-1:0] span_vec [rrbl_pkg::EP_SLOTS];
  int                      edge_total;
  int                      active_rules;
  logic [1:0]              domain_sel;

  answer_t answers_due[$];
  int      errors;
  int      cycles;
  int      sent;
  bit      tx_burst;
  bit      rx_burst;
  int      rx_hold;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL range_rule_bitvector_lookup");
      $finish;
    end
  end

  function automatic void insert_edge(logic [rrbl_pkg::KW-1:0] v);
    int pos;
    pos = 0;
    while (pos < edge_total && edges[pos] < v) pos++;
    if (pos < edge_total && edges[pos] == v) return;
    if (pos >= rrbl_pkg::EP_SLOTS) return;
    if (edge_total < rrbl_pkg::EP_SLOTS) edge_total++;
    for (int k = edge_total - 1; k > pos; k--) edges[k] = edges[k-1];
    edges[pos] = v;
  endfunction

  function automatic void rebuild_intervals();
    int n;
    logic [rrbl_pkg::KW-1:0] dmax;
    n = (active_rules > rrbl_pkg::RULE_SLOTS) ? rrbl_pkg::RULE_SLOTS : active_rules;
    dmax = (domain_sel == rrbl_pkg::DOM_32) ? rrbl_pkg::DMAX_32 :
           (domain_sel == rrbl_pkg::DOM_8) ? rrbl_pkg::DMAX_8 : rrbl_pkg::DMAX_16;
    edge_total = 0;
    insert_edge('0);
    insert_edge(dmax);
    for (int r = 0; r < n; r++) begin
      insert_edge(bnd_lo[r]);
      insert_edge(bnd_hi[r]);
    end
    for (int i = 0; i < edge_total; i++) begin
      edge_vec[i] = '0;
      span_vec[i] = '0;
      for (int r = 0; r < n; r++) begin
        if (bnd_lo[r] <= edges[i] && bnd_hi[r] >= edges[i]) edge_vec[i][r] = 1'b1;
        if (i + 1 < edge_total && bnd_lo[r] <= edges[i] && bnd_hi[r] >= edges[i+1])
          span_vec[i][r] = 1'b1;
      end
    end
  endfunction

  function automatic logic [rrbl_pkg::VW-1:0] classify_key(logic [rrbl_pkg::KW-1:0] key);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = edge_total;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (edges[mid] <= key) lo = mid + 1;
      else hi = mid;
    end
    if (lo == 0) return '0;
    lo--;
    if (edges[lo] == key) return edge_vec[lo];
    if (lo + 1 >= edge_total) return '0;
    return span_vec[lo];
  endfunction

  // updates the mirror for one accepted item; returns 1 when it yields an answer
  function automatic bit apply_item(logic [1:0] a, logic [rrbl_pkg::RW-1:0] idx,
                                    logic [rrbl_pkg::KW-1:0] lo,
                                    logic [rrbl_pkg::KW-1:0] hi,
                                    logic [rrbl_pkg::KW-1:0] key, output answer_t ans);
    ans.kind = 1'b0;
    ans.vec = '0;
    ans.cnt = '0;
    case (a)
      rrbl_pkg::ACT_LOAD: begin
        bnd_lo[idx] = lo;
        bnd_hi[idx] = hi;
        return 1'b0;
      end
      rrbl_pkg::ACT_BUILD: begin
        rebuild_intervals();
        ans.kind = 1'b1;
        return 1'b1;
      end
      rrbl_pkg::ACT_LOOKUP: begin
        ans.vec = classify_key(key);
        ans.cnt = rrbl_pkg::CW'($countones(ans.vec));
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic send_item(logic [1:0] a, logic [rrbl_pkg::RW-1:0] idx,
                           logic [rrbl_pkg::KW-1:0] lo, logic [rrbl_pkg::KW-1:0] hi,
                           logic [rrbl_pkg::KW-1:0] key, bit typed,
                           logic [rrbl_pkg::VW-1:0] typed_vec);
    int gap;
    answer_t ans;
    gap = tx_burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    action     <= a;
    rule_index <= idx;
    range_low  <= lo;
    range_high <= hi;
    search_key <= key;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    if (apply_item(a, idx, lo, hi, key, ans)) begin
      if (typed) begin
        ans.vec = typed_vec;
        ans.cnt = rrbl_pkg::CW'($countones(typed_vec));
      end
      answers_due.push_back(ans);
    end
    if ($urandom_range(0, 30) == 0) tx_burst = !tx_burst;
  endtask

  // block is idle: no answer pending and any load has settled
  task automatic drain();
    in_valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_config(logic [rrbl_pkg::CW-1:0] rc, logic [1:0] dom);
    cfg_write <= 1'b1;
    cfg_index <= rrbl_pkg::CFG_RULE_COUNT;
    cfg_data  <= rc;
    @(posedge clk);
    cfg_index <= rrbl_pkg::CFG_KEY_DOMAIN;
    cfg_data  <= {5'd0, dom};
    @(posedge clk);
    cfg_write <= 1'b0;
    active_rules = rc;
    domain_sel = dom;
  endtask

  function automatic logic [rrbl_pkg::KW-1:0] pick_bound();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 300);
      2: return $urandom_range(65530, 65540);
      3: return $urandom_range(0, 1) ? rrbl_pkg::DMAX_32 : '0;
      4: return $urandom_range(0, 40);
      default: return $urandom_range(0, 70000);
    endcase
  endfunction

  task automatic send_load(logic [rrbl_pkg::RW-1:0] idx);
    logic [rrbl_pkg::KW-1:0] a;
    logic [rrbl_pkg::KW-1:0] b;
    a = pick_bound();
    b = pick_bound();
    // mostly ordered ranges, some reversed ones that cover nothing
    if ($urandom_range(0, 9) != 0 && a > b)
      send_item(rrbl_pkg::ACT_LOAD, idx, b, a, $urandom(), 1'b0, '0);
    else
      send_item(rrbl_pkg::ACT_LOAD, idx, a, b, $urandom(), 1'b0, '0);
  endtask

  task automatic send_lookup();
    logic [rrbl_pkg::KW-1:0] key;
    int r;
    r = $urandom_range(0, rrbl_pkg::RULE_SLOTS - 1);
    case ($urandom_range(0, 3))
      0: key = bnd_lo[r] + rrbl_pkg::KW'($urandom_range(0, 2)) - 1;
      1: key = bnd_hi[r] + rrbl_pkg::KW'($urandom_range(0, 2)) - 1;
      default: key = $urandom_range(0, 1) ? pick_bound() : rrbl_pkg::KW'($urandom());
    endcase
    send_item(rrbl_pkg::ACT_LOOKUP, rrbl_pkg::RW'($urandom()), $urandom(), $urandom(), key,
              1'b0, '0);
  endtask

  // directed stimulus
  row_t plan [] = '{
    '{0, 0, 0, rrbl_pkg::ACT_LOOKUP, 0, 0, 0, 32'd5, 1, 64'd0},
    '{0, 0, 0, rrbl_pkg::ACT_NONE, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
      0, 64'd0},
    '{0, 0, 0, rrbl_pkg::ACT_BUILD, 0, 0, 0, 0, 1, 64'd0},
    '{0, 0, 0, rrbl_pkg::ACT_LOOKUP, 0, 0, 0, 32'd0, 1, 64'd0},
    '{0, 0, 0, rrbl_pkg::ACT_LOOKUP, 0, 0, 0, 32'hFFFF_FFFF, 1, 64'd0},
    '{0, 0, 0, rrbl_pkg::ACT_LOAD, 6'd0, 32'd5, 32'd5, 0, 0, 64'd0},
    '{0, 0, 0, rrbl_pkg::ACT_LOAD, 6'd1, 32'd100, 32'd10, 0, 0, 64'd0},
    '{0, 0, 0, rrbl_pkg::ACT_LOAD, 6'd2, 32'd200, 32'd300, 0, 0, 64'd0},
    '{0, 0, 0, rrbl_pkg::ACT_LOAD, 6'd3, 32'd0, 32'hFFFF_FFFF, 0, 0, 64'd0},
    '{0, 0, 0, rrbl_pkg::ACT_LOAD, 6'd4, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 64'd0},
    '{1, 7'd3, rrbl_pkg::DOM_8, rrbl_pkg::ACT_BUILD, 0, 0, 0, 0, 1, 64'd0},
    '{0, 0, 0, rrbl_pkg::ACT_LOOKUP, 0, 0, 0, 32'd301, 1, 64'd0},
    '{0, 0, 0, rrbl_pkg::ACT_LOOKUP, 0, 0, 0, 32'd5, 1, 64'd1},
    '{0, 0, 0, rrbl_pkg::ACT_LOOKUP, 0, 0, 0, 32'd50, 0, 64'd0},
    '{0, 0, 0, rrbl_pkg::ACT_LOOKUP, 0, 0, 0, 32'd250, 0, 64'd0},
    '{1, 7'd5, 2'd3, rrbl_pkg::ACT_BUILD, 0, 0, 0, 0, 1, 64'd0},
    '{0, 0, 0, rrbl_pkg::ACT_LOOKUP, 0, 0, 0, 32'd0, 0, 64'd0},
    '{0, 0, 0, rrbl_pkg::ACT_LOOKUP, 0, 0, 0, 32'd65535, 0, 64'd0},
    '{0, 0, 0, rrbl_pkg::ACT_LOOKUP, 0, 0, 0, 32'd65536, 0, 64'd0},
    '{0, 0, 0, rrbl_pkg::ACT_LOOKUP, 0, 0, 0, 32'hFFFF_FFFF, 0, 64'd0}
  };

  // result side: random stall per item
  always @(posedge clk) begin
    int w;
    if (rst) begin
      out_ready <= 1'b0;
      rx_hold <= 0;
    end else if (out_valid && out_ready) begin
      if ($urandom_range(0, 40) == 0) rx_burst <= !rx_burst;
      w = rx_burst ? 0 : $urandom_range(0, 7);
      rx_hold <= w;
      out_ready <= (w == 0);
    end else if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
      out_ready <= (rx_hold == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    answer_t want;
    if (!rst && out_valid && out_ready) begin
      if (answers_due.size() == 0) begin
        $error("unexpected item: kind %0d vector %h count %0d",
               result_kind, match_vector, match_count);
        errors++;
      end else begin
        want = answers_due.pop_front();
        if (result_kind !== want.kind) begin
          $error("result_kind expected %0d actual %0d", want.kind, result_kind);
          errors++;
        end
        if (match_vector !== want.vec) begin
          $error("match_vector expected %h actual %h", want.vec, match_vector);
          errors++;
        end
        if (match_count !== want.cnt) begin
          $error("match_count expected %0d actual %0d", want.cnt, match_count);
          errors++;
        end
      end
    end
  end

  initial begin
    int big_builds;
    int n;
    logic [rrbl_pkg::CW-1:0] rc;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = rrbl_pkg::CFG_RULE_COUNT;
    cfg_data = '0;
    in_valid = 1'b0;
    action = rrbl_pkg::ACT_NONE;
    rule_index = '0;
    range_low = '0;
    range_high = '0;
    search_key = '0;
    sent = 0;
    tx_burst = 0;
    big_builds = 0;
    edge_total = 0;
    active_rules = 0;
    domain_sel = rrbl_pkg::DOM_32;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_config(7'd0, rrbl_pkg::DOM_32);

    foreach (plan[i]) begin
      if (plan[i].sync) begin
        drain();
        write_config(plan[i].rc, plan[i].dom);
      end
      send_item(plan[i].act, plan[i].idx, plan[i].lo, plan[i].hi, plan[i].key,
                plan[i].typed, plan[i].vec);
    end

    // fill every slot so any rule count is legal from here on
    for (int s = 0; s < rrbl_pkg::RULE_SLOTS; s++) send_load(rrbl_pkg::RW'(s));

    while (sent < 1800) begin
      drain();
      case ($urandom_range(0, 19))
        0: rc = (big_builds < 4) ? rrbl_pkg::RULE_MAX : 7'd1;
        1: rc = (big_builds < 4) ? 7'd127 : 7'd2;
        2: rc = 7'd0;
        default: rc = rrbl_pkg::CW'($urandom_range(1, 10));
      endcase
      if (rc >= rrbl_pkg::RULE_MAX) big_builds++;
      write_config(rc, 2'($urandom_range(0, 3)));
      n = $urandom_range(0, 4);
      repeat (n) send_load(rrbl_pkg::RW'($urandom_range(0, 10)));
      send_item(rrbl_pkg::ACT_BUILD, rrbl_pkg::RW'($urandom()), $urandom(), $urandom(),
                $urandom(), 1'b0, '0);
      repeat (40) begin
        case ($urandom_range(0, 19))
          0, 1: send_load(rrbl_pkg::RW'($urandom_range(0, rrbl_pkg::RULE_SLOTS - 1)));
          2: send_item(rrbl_pkg::ACT_NONE, rrbl_pkg::RW'($urandom()), $urandom(), $urandom(),
                       $urandom(), 1'b0, '0);
          3: begin
            if (rc <= 7'd10)
              send_item(rrbl_pkg::ACT_BUILD, rrbl_pkg::RW'($urandom()), $urandom(),
                        $urandom(), $urandom(), 1'b0, '0);
            else
              send_lookup();
          end
          default: send_lookup();
        endcase
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0)
      $display("PASS range_rule_bitvector_lookup");
    else
      $display("FAIL range_rule_bitvector_lookup");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/rrbl_pkg.sv
hw/rtl/rrbl_ctrl.sv
hw/rtl/rrbl_datapath.sv
hw/rtl/range_rule_bitvector_lookup.sv
tb/tb_top.sv
